FILE: src/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg: shared types and constants of the beacon decider
// Beat payloads, register indexes and reset values, cause codes, scale
// constants, serial unit widths and the course difference helper.
// ----------------------------------------------------------------------------
package abd_pkg;

    // input beat: one position fix
    typedef struct packed {
        logic [15:0]        speed_cmps;
        logic [15:0]        course_cdeg;
        logic               course_ok;
        logic signed [31:0] time_s;
    } t_in;

    // output beat: decision for one fix
    typedef struct packed {
        logic        beacon;
        logic [1:0]  cause;
        logic [15:0] rate_s;
    } t_out;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_KMH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_KMH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_TIME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_SLOPE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_INT = 3'd7;

    // configuration reset values
    localparam logic [7:0]  RST_FAST_KMH   = 8'd100;
    localparam logic [15:0] RST_FAST_RATE  = 16'd180;
    localparam logic [7:0]  RST_SLOW_KMH   = 8'd10;
    localparam logic [15:0] RST_SLOW_RATE  = 16'd1800;
    localparam logic [15:0] RST_TURN_TIME  = 16'd15;
    localparam logic [7:0]  RST_TURN_MIN   = 8'd10;
    localparam logic [15:0] RST_TURN_SLOPE = 16'd240;
    localparam logic [15:0] RST_FIXED_INT  = 16'd0;

    // cause codes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_FIRST  = 2'd1;
    localparam logic [1:0] CAUSE_CORNER = 2'd2;
    localparam logic [1:0] CAUSE_RATE   = 2'd3;

    // scale constants
    localparam logic [17:0] MPH_NUM      = 18'd44704;
    localparam logic [16:0] DEG_FULL     = 17'd36000;
    localparam logic [16:0] DEG_HALF     = 17'd18000;
    localparam logic [6:0]  CDEG_PER_DEG = 7'd100;
    localparam logic [9:0]  KMH_SCALE    = 10'd1000;

    // serial multiplier: a is held, b is shifted out one bit per cycle while busy
    localparam int MUL_A_W   = 20;
    localparam int MUL_B_W   = 16;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // serial divider: one quotient bit per cycle while busy
    localparam int DIV_Q_W   = 16;
    localparam int DIV_D_W   = 18;
    localparam int DIV_N_W   = DIV_Q_W + DIV_D_W;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    // folded course difference in centidegrees, 0 to 18000
    function automatic logic [16:0] turn_angle(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        begin
            d = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
            if (d >= DEG_FULL) begin
                d = d - DEG_FULL;
            end
            if (d > DEG_HALF) begin
                d = DEG_FULL - d;
            end
            return d;
        end
    endfunction

endpackage

FILE: src/adaptive_beacon_decider_core.sv
// sequence: a fix runs through the prepare, multiply, divide, rate and finish
//   states, finish waiting for a free output register; no new fix is taken
//   until idle again. The steps use 16-bit serial units: three shift-add
//   multipliers side by side, then the restoring rate divider
// reset: synchronous active low; registers take their reset values, the
//   stored fix is cleared, no beat is pending and ready rises at once
// ----------------------------------------------------------------------------
// adaptive_beacon_decider_core: speed and turn driven beacon decision
// Keeps the last beaconed fix, computes the speed-dependent interval and
// decides per fix: first fix, corner peg, interval elapsed or no beacon.
// ----------------------------------------------------------------------------
module adaptive_beacon_decider_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [abd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [abd_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // fix input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  abd_pkg::t_in                     i_in,
    // decision output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output abd_pkg::t_out                    o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MST  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DST  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_RATE = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    // configuration registers
    logic [7:0]  r_fast_kmh;
    logic [15:0] r_fast_rate;
    logic [7:0]  r_slow_kmh;
    logic [15:0] r_slow_rate;
    logic [15:0] r_turn_time;
    logic [7:0]  r_turn_min;
    logic [15:0] r_turn_slope;
    logic [15:0] r_fixed_int;

    // stored fix
    logic               r_have_last;
    logic               r_last_ok;
    logic [15:0]        r_last_course;
    logic signed [31:0] r_last_time;

    // sequencer and current fix
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [15:0]        r_spd;
    logic [15:0]        r_crs;
    logic               r_ok;
    logic signed [31:0] r_tnow;

    // prepared operands and flags
    logic [32:0] r_t;
    logic        r_t_ge_turn;
    logic        r_le_s;
    logic        r_ge_f;
    logic        r_up;
    logic [17:0] r_num;
    logic [17:0] r_den;
    logic [15:0] r_diff;
    logic [19:0] r_spd10;
    logic [15:0] r_dd;
    logic        r_d_gt_base;
    logic        r_spd_nz;
    logic        r_turn_big;
    logic [15:0] r_rate;

    logic [32:0] n_t;
    logic        n_t_ge_turn;
    logic        n_le_s;
    logic        n_ge_f;
    logic        n_up;
    logic [17:0] n_num;
    logic [17:0] n_den;
    logic [15:0] n_diff;
    logic [19:0] n_spd10;
    logic [15:0] n_dd;
    logic        n_d_gt_base;
    logic [21:0] n_v;
    logic [17:0] n_s;
    logic [17:0] n_f;
    logic [16:0] n_d;
    logic [16:0] n_base;
    logic [15:0] n_rate;
    logic [1:0]  n_cause;
    logic        n_peg;
    logic        n_t_ge_rate;

    // output register
    logic          r_out_valid;
    abd_pkg::t_out r_out;

    // serial unit wiring
    logic                          mul_go;
    logic                          div_go;
    logic                          mr_done;
    logic                          mc_done;
    logic                          mk_done;
    logic [abd_pkg::MUL_P_W-1:0]   mr_prod;
    logic [abd_pkg::MUL_P_W-1:0]   mc_prod;
    logic [abd_pkg::MUL_P_W-1:0]   mk_prod;
    logic                          div_done;
    logic [abd_pkg::DIV_Q_W-1:0]   div_quo;
    logic                          div_rem_nz;
    logic                          in_fire;
    logic                          fin_go;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign fin_go      = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign mul_go      = (r_state == S_MST);
    assign div_go      = (r_state == S_DST);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_kmh   <= abd_pkg::RST_FAST_KMH;
            r_fast_rate  <= abd_pkg::RST_FAST_RATE;
            r_slow_kmh   <= abd_pkg::RST_SLOW_KMH;
            r_slow_rate  <= abd_pkg::RST_SLOW_RATE;
            r_turn_time  <= abd_pkg::RST_TURN_TIME;
            r_turn_min   <= abd_pkg::RST_TURN_MIN;
            r_turn_slope <= abd_pkg::RST_TURN_SLOPE;
            r_fixed_int  <= abd_pkg::RST_FIXED_INT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                abd_pkg::CFG_FAST_KMH:   r_fast_kmh   <= i_cfg_data[7:0];
                abd_pkg::CFG_FAST_RATE:  r_fast_rate  <= i_cfg_data;
                abd_pkg::CFG_SLOW_KMH:   r_slow_kmh   <= i_cfg_data[7:0];
                abd_pkg::CFG_SLOW_RATE:  r_slow_rate  <= i_cfg_data;
                abd_pkg::CFG_TURN_TIME:  r_turn_time  <= i_cfg_data;
                abd_pkg::CFG_TURN_MIN:   r_turn_min   <= i_cfg_data[7:0];
                abd_pkg::CFG_TURN_SLOPE: r_turn_slope <= i_cfg_data;
                abd_pkg::CFG_FIXED_INT:  r_fixed_int  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand preparation: speeds, interpolation terms, turn angle, elapsed time
    always_comb begin
        n_v     = ({6'd0, r_spd} << 5) + ({6'd0, r_spd} << 2);
        n_s     = 18'(r_slow_kmh) * 18'(abd_pkg::KMH_SCALE);
        n_f     = 18'(r_fast_kmh) * 18'(abd_pkg::KMH_SCALE);
        n_le_s  = (n_v <= {4'd0, n_s});
        n_ge_f  = (n_v >= {4'd0, n_f});
        n_num   = n_f - n_v[17:0];
        n_den   = n_f - n_s;
        n_up    = (r_slow_rate >= r_fast_rate);
        n_diff  = n_up ? (r_slow_rate - r_fast_rate) : (r_fast_rate - r_slow_rate);
        n_spd10 = ({4'd0, r_spd} << 3) + ({4'd0, r_spd} << 1);
        n_d     = abd_pkg::turn_angle(r_crs, r_last_course);
        n_base  = 17'(r_turn_min) * 17'(abd_pkg::CDEG_PER_DEG);
        n_d_gt_base = (n_d > n_base);
        n_dd    = 16'(n_d - n_base);
        n_t     = {r_tnow[31], r_tnow} - {r_last_time[31], r_last_time};
        n_t_ge_turn = ($signed(n_t) >= $signed({17'd0, r_turn_time}));
    end

    // rate selection: slow or fast setting at the ends, else from the divider result
    always_comb begin
        if (r_le_s) begin
            n_rate = r_slow_rate;
        end else if (r_ge_f) begin
            n_rate = r_fast_rate;
        end else if (r_up) begin
            n_rate = r_fast_rate + div_quo;
        end else begin
            n_rate = r_fast_rate - (div_quo + {15'd0, div_rem_nz});
        end
    end

    // decision
    always_comb begin
        n_t_ge_rate = ($signed(r_t) >= $signed({17'd0, r_rate}));
        n_peg = r_ok && r_spd_nz && r_t_ge_turn &&
                (!r_last_ok || (r_d_gt_base && r_turn_big));
        if (r_fixed_int != 16'd0) begin
            n_cause = abd_pkg::CAUSE_NONE;
        end else if (!r_have_last) begin
            n_cause = abd_pkg::CAUSE_FIRST;
        end else if (n_peg) begin
            n_cause = abd_pkg::CAUSE_CORNER;
        end else if (n_t_ge_rate) begin
            n_cause = abd_pkg::CAUSE_RATE;
        end else begin
            n_cause = abd_pkg::CAUSE_NONE;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_fire) n_state = S_PREP;
            S_PREP: n_state = S_MST;
            S_MST:  n_state = S_MUL;
            S_MUL:  if (mr_done) n_state = S_DST;
            S_DST:  n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_RATE;
            S_RATE: n_state = S_FIN;
            S_FIN:  if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // fix capture and working registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_spd  <= i_in.speed_cmps;
            r_crs  <= i_in.course_cdeg;
            r_ok   <= i_in.course_ok;
            r_tnow <= i_in.time_s;
        end
        if (r_state == S_PREP) begin
            r_t         <= n_t;
            r_t_ge_turn <= n_t_ge_turn;
            r_le_s      <= n_le_s;
            r_ge_f      <= n_ge_f;
            r_up        <= n_up;
            r_num       <= n_num;
            r_den       <= n_den;
            r_diff      <= n_diff;
            r_spd10     <= n_spd10;
            r_dd        <= n_dd;
            r_d_gt_base <= n_d_gt_base;
            r_spd_nz    <= (r_spd != 16'd0);
        end
        if (r_state == S_DST) begin
            r_turn_big <= (mc_prod > mk_prod);
        end
        if (r_state == S_RATE) begin
            r_rate <= n_rate;
        end
    end

    // stored fix update on a beacon
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last   <= 1'b0;
            r_last_ok     <= 1'b0;
            r_last_course <= 16'd0;
            r_last_time   <= 32'sd0;
        end else if (fin_go && n_cause != abd_pkg::CAUSE_NONE) begin
            r_have_last   <= 1'b1;
            r_last_ok     <= r_ok;
            r_last_course <= r_crs;
            r_last_time   <= r_tnow;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out.beacon <= (n_cause != abd_pkg::CAUSE_NONE);
            r_out.cause  <= n_cause;
            r_out.rate_s <= r_rate;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // rate numerator product: rate span times distance below fast speed
    abd_mul u_mul_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     ({2'd0, r_num}),
        .i_b     (r_diff),
        .o_done  (mr_done),
        .o_prod  (mr_prod)
    );

    // corner left side: excess turn times speed times ten
    abd_mul u_mul_turn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (r_spd10),
        .i_b     (r_dd),
        .o_done  (mc_done),
        .o_prod  (mc_prod)
    );

    // corner right side: slope times the mph scale
    abd_mul u_mul_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     ({2'd0, abd_pkg::MPH_NUM}),
        .i_b     (r_turn_slope),
        .o_done  (mk_done),
        .o_prod  (mk_prod)
    );

    // interpolation divide
    abd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_go),
        .i_num    (mr_prod[abd_pkg::DIV_N_W-1:0]),
        .i_den    (r_den),
        .o_done   (div_done),
        .o_quo    (div_quo),
        .o_rem_nz (div_rem_nz)
    );

    // checks
    a_units_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mr_done |-> (mc_done && mk_done && r_state == S_MUL))
        else $error("serial multipliers out of step with the sequencer");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_beacon_stores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && n_cause != abd_pkg::CAUSE_NONE) |=> r_have_last)
        else $error("beacon did not store the fix");

    a_fixed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && r_fixed_int != 16'd0) |=> (o_out_valid && !o_out.beacon))
        else $error("beacon raised in fixed interval mode");

    a_beacon_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.beacon == (o_out.cause != abd_pkg::CAUSE_NONE)))
        else $error("beacon flag disagrees with cause");

endmodule

FILE: src/abd_mul.sv
// ----------------------------------------------------------------------------
// abd_mul: bit-serial shift-add multiplier
// Takes one multiplier bit per cycle while busy; the product is ready when
// done rises, after all MUL_B_W bits, and holds until the next start.
// ----------------------------------------------------------------------------
module abd_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [abd_pkg::MUL_A_W-1:0]   i_a,
    input  logic [abd_pkg::MUL_B_W-1:0]   i_b,
    output logic                          o_done,
    output logic [abd_pkg::MUL_P_W-1:0]   o_prod
);

    localparam logic [abd_pkg::MUL_CNT_W-1:0] LAST_STEP =
        abd_pkg::MUL_CNT_W'(abd_pkg::MUL_B_W - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [abd_pkg::MUL_CNT_W-1:0]   r_cnt;
    logic [abd_pkg::MUL_A_W-1:0]     r_a;
    logic [abd_pkg::MUL_A_W-1:0]     r_hi;
    logic [abd_pkg::MUL_B_W-1:0]     r_lo;
    logic [abd_pkg::MUL_A_W:0]       n_sum;

    // partial sum for the current multiplier bit
    always_comb begin
        n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath: add then shift right one bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_sum[abd_pkg::MUL_A_W:1];
            r_lo <= {n_sum[0], r_lo[abd_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

FILE: src/abd_div.sv
// ----------------------------------------------------------------------------
// abd_div: bit-serial restoring divider
// Gives one quotient bit per cycle; the dividend's upper part must stay
// below the divisor, so the quotient fits DIV_Q_W bits.
// ----------------------------------------------------------------------------
module abd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [abd_pkg::DIV_N_W-1:0]   i_num,
    input  logic [abd_pkg::DIV_D_W-1:0]   i_den,
    output logic                          o_done,
    output logic [abd_pkg::DIV_Q_W-1:0]   o_quo,
    output logic                          o_rem_nz
);

    localparam logic [abd_pkg::DIV_CNT_W-1:0] LAST_STEP =
        abd_pkg::DIV_CNT_W'(abd_pkg::DIV_Q_W - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [abd_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [abd_pkg::DIV_D_W-1:0]     r_den;
    logic [abd_pkg::DIV_D_W-1:0]     r_rem;
    logic [abd_pkg::DIV_Q_W-1:0]     r_q;
    logic [abd_pkg::DIV_D_W:0]       n_trial;
    logic [abd_pkg::DIV_D_W:0]       n_diff;
    logic                            n_ge;

    // trial subtract for the next quotient bit
    always_comb begin
        n_trial = {r_rem, r_q[abd_pkg::DIV_Q_W-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath: dividend bits shift in, quotient bits shift in behind them
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_num[abd_pkg::DIV_N_W-1:abd_pkg::DIV_Q_W];
            r_q   <= i_num[abd_pkg::DIV_Q_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[abd_pkg::DIV_D_W-1:0] : n_trial[abd_pkg::DIV_D_W-1:0];
            r_q   <= {r_q[abd_pkg::DIV_Q_W-2:0], n_ge};
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_q;
    assign o_rem_nz = (r_rem != '0);

endmodule

FILE: tb/adaptive_beacon_decider_core_test.sv
// ----------------------------------------------------------------------------
// adaptive_beacon_decider_core_test: self-checking bench for the beacon decider
// Sends position fixes through the valid/ready input channel. A bit-exact
// predictor works out the decision for every accepted fix, and the monitor
// compares each output beat against it. The registers are reprogrammed
// between rounds while the block is idle.
// ----------------------------------------------------------------------------
module adaptive_beacon_decider_core_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ROUNDS         = 10;
    localparam int FIXES_PER_ROUND = 165;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [abd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [abd_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    abd_pkg::t_in                  i_in = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    abd_pkg::t_out                 o_out;

    adaptive_beacon_decider_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [7:0]  reg_fast_kmh   = abd_pkg::RST_FAST_KMH;
    logic [15:0] reg_fast_rate  = abd_pkg::RST_FAST_RATE;
    logic [7:0]  reg_slow_kmh   = abd_pkg::RST_SLOW_KMH;
    logic [15:0] reg_slow_rate  = abd_pkg::RST_SLOW_RATE;
    logic [15:0] reg_turn_time  = abd_pkg::RST_TURN_TIME;
    logic [7:0]  reg_turn_min   = abd_pkg::RST_TURN_MIN;
    logic [15:0] reg_turn_slope = abd_pkg::RST_TURN_SLOPE;
    logic [15:0] reg_fixed      = abd_pkg::RST_FIXED_INT;

    // predictor copy of the last beaconed fix
    bit          have_fix = 1'b0;
    bit          held_ok = 1'b0;
    logic [15:0] held_course = '0;
    longint      held_time = 0;

    abd_pkg::t_in  fixes_to_send[$];
    abd_pkg::t_out pending_decisions[$];
    int   mismatch_count = 0;
    int   idle_pct = 34;
    int   quiet_cycles = 0;
    bit   in_taken = 1'b0;

    // random track state
    int track_time = 0;
    int track_course = 0;

    // speed-dependent interval, linear between slow and fast settings
    function automatic logic [15:0] interval_for(input logic [15:0] spd);
        longint unsigned v, s, f, fast, slow, num, den;
        v = longint'(spd) * 36;
        s = longint'(reg_slow_kmh) * abd_pkg::KMH_SCALE;
        f = longint'(reg_fast_kmh) * abd_pkg::KMH_SCALE;
        fast = reg_fast_rate;
        slow = reg_slow_rate;
        if (v <= s) return reg_slow_rate;
        if (v >= f) return reg_fast_rate;
        num = f - v;
        den = f - s;
        if (slow >= fast) begin
            return 16'(fast + ((slow - fast) * num) / den);
        end
        // rising rate with speed: round the step up
        return 16'(fast - ((fast - slow) * num + den - 1) / den);
    endfunction

    // sharp enough turn after the minimum time
    function automatic bit turn_pegged(input abd_pkg::t_in fix, input longint elapsed);
        longint unsigned d, base, spd;
        if (!fix.course_ok || fix.speed_cmps == 0) return 1'b0;
        if (elapsed < longint'(reg_turn_time)) return 1'b0;
        if (!held_ok) return 1'b1;
        d = (fix.course_cdeg >= held_course) ? fix.course_cdeg - held_course
                                             : held_course - fix.course_cdeg;
        d = d % abd_pkg::DEG_FULL;
        if (d > abd_pkg::DEG_HALF) d = abd_pkg::DEG_FULL - d;
        base = longint'(reg_turn_min) * abd_pkg::CDEG_PER_DEG;
        if (d <= base) return 1'b0;
        spd = fix.speed_cmps;
        return (d - base) * spd * 10 > longint'(reg_turn_slope) * abd_pkg::MPH_NUM;
    endfunction

    // decision for one fix; stores the fix on a beacon
    function automatic abd_pkg::t_out decide_fix(input abd_pkg::t_in fix);
        abd_pkg::t_out res;
        longint        tnow, elapsed;
        logic [1:0]    why;
        tnow = $signed(fix.time_s);
        elapsed = tnow - held_time;
        res.rate_s = interval_for(fix.speed_cmps);
        why = abd_pkg::CAUSE_NONE;
        if (reg_fixed == 0) begin
            if (!have_fix) why = abd_pkg::CAUSE_FIRST;
            else if (turn_pegged(fix, elapsed)) why = abd_pkg::CAUSE_CORNER;
            else if (elapsed >= longint'(res.rate_s)) why = abd_pkg::CAUSE_RATE;
        end
        if (why != abd_pkg::CAUSE_NONE) begin
            have_fix = 1'b1;
            held_ok = fix.course_ok;
            held_course = fix.course_cdeg;
            held_time = tnow;
        end
        res.beacon = (why != abd_pkg::CAUSE_NONE);
        res.cause = why;
        return res;
    endfunction

    function automatic void apply_reg(input logic [abd_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [15:0] data);
        case (idx)
            abd_pkg::CFG_FAST_KMH:   reg_fast_kmh = data[7:0];
            abd_pkg::CFG_FAST_RATE:  reg_fast_rate = data;
            abd_pkg::CFG_SLOW_KMH:   reg_slow_kmh = data[7:0];
            abd_pkg::CFG_SLOW_RATE:  reg_slow_rate = data;
            abd_pkg::CFG_TURN_TIME:  reg_turn_time = data;
            abd_pkg::CFG_TURN_MIN:   reg_turn_min = data[7:0];
            abd_pkg::CFG_TURN_SLOPE: reg_turn_slope = data;
            abd_pkg::CFG_FIXED_INT:  reg_fixed = data;
            default: ;
        endcase
    endfunction

    // random fix: a wandering track with turns, jumps and time going back
    function automatic abd_pkg::t_in next_fix();
        abd_pkg::t_in f;
        int unsigned  r;
        r = $urandom_range(99);
        if (r < 10) f.speed_cmps = 16'd0;
        else if (r < 80) f.speed_cmps = 16'($urandom_range(4500));
        else f.speed_cmps = 16'($urandom);
        r = $urandom_range(99);
        if (r < 50) track_course = (track_course + int'($urandom_range(400)) + 35800) % 36000;
        else if (r < 85) track_course = int'($urandom_range(35999));
        f.course_cdeg = (r >= 95) ? 16'($urandom_range(65535)) : 16'(track_course);
        f.course_ok = ($urandom_range(99) < 85);
        r = $urandom_range(99);
        if (r < 85) track_time += int'($urandom_range(60));
        else if (r < 92) track_time += int'($urandom_range(4000));
        else if (r < 96) track_time -= int'($urandom_range(100));
        else track_time = int'($urandom);
        f.time_s = track_time;
        return f;
    endfunction

    task automatic push_fix(input logic [15:0] spd, input logic [15:0] crs,
                            input logic ok, input logic [31:0] tm);
        abd_pkg::t_in f;
        f.speed_cmps = spd;
        f.course_cdeg = crs;
        f.course_ok = ok;
        f.time_s = tm;
        fixes_to_send.push_back(f);
    endtask

    // one register write; entered and left at a falling edge
    task automatic write_reg(input logic [abd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        @(negedge i_clk);
    endtask

    // register set for one round: extremes first, then sensible random ones
    task automatic program_settings(input int round);
        logic [15:0] v[8];
        logic [15:0] tmp;
        case (round)
            1: v = '{default: 16'h0000};
            2: v = '{default: 16'hFFFF};
            3: begin
                v = '{default: 16'hFFFF};
                v[abd_pkg::CFG_FIXED_INT] = 16'd0;
            end
            default: begin
                v[abd_pkg::CFG_FAST_KMH]   = {8'($urandom), 8'($urandom_range(40, 160))};
                v[abd_pkg::CFG_FAST_RATE]  = 16'($urandom_range(30, 300));
                v[abd_pkg::CFG_SLOW_KMH]   = {8'($urandom), 8'($urandom_range(40))};
                v[abd_pkg::CFG_SLOW_RATE]  = 16'($urandom_range(300, 3000));
                v[abd_pkg::CFG_TURN_TIME]  = 16'($urandom_range(30));
                v[abd_pkg::CFG_TURN_MIN]   = ($urandom_range(3) == 0) ? 16'($urandom)
                                                                      : 16'($urandom_range(40));
                v[abd_pkg::CFG_TURN_SLOPE] = 16'($urandom_range(600));
                v[abd_pkg::CFG_FIXED_INT]  = (round == 5) ? 16'd1 : 16'd0;
                // rate that rises with speed
                if ($urandom_range(9) < 3) begin
                    tmp = v[abd_pkg::CFG_FAST_RATE];
                    v[abd_pkg::CFG_FAST_RATE] = v[abd_pkg::CFG_SLOW_RATE];
                    v[abd_pkg::CFG_SLOW_RATE] = tmp;
                end
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            write_reg(abd_pkg::CFG_IDX_W'(i), v[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // wait at a falling edge until nothing is queued, in flight or expected
    task automatic wait_idle();
        do @(negedge i_clk);
        while (fixes_to_send.size() != 0 || i_in_valid || pending_decisions.size() != 0);
    endtask

    // fix driver and result receiver, both with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (fixes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in <= fixes_to_send.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // monitor: predict on input beats, check output beats, watchdog
    always @(posedge i_clk) begin
        abd_pkg::t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_decisions.size() == 0) begin
                    $display("%0t unexpected beat: actual beacon=%0d cause=%0d rate=%0d",
                             $time, o_out.beacon, o_out.cause, o_out.rate_s);
                    mismatch_count++;
                end else begin
                    want = pending_decisions.pop_front();
                    if (o_out.beacon !== want.beacon || o_out.cause !== want.cause ||
                        o_out.rate_s !== want.rate_s) begin
                        $display("%0t mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                                 $time, want.beacon, want.cause, want.rate_s,
                                 o_out.beacon, o_out.cause, o_out.rate_s);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending_decisions.push_back(decide_fix(i_in));
            end
            in_taken <= i_in_valid && o_in_ready;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[adaptive_beacon_decider_core] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed fixes under the reset settings
        push_fix(16'd0, 16'd0, 1'b0, 32'd0);                 // first fix
        push_fix(16'd0, 16'd0, 1'b0, -32'sd100);             // time going back
        push_fix(16'hFFFF, 16'd35999, 1'b1, 32'd1799);       // peg, stored course invalid
        push_fix(16'd277, 16'd0, 1'b1, 32'd1800);            // just inside slow speed
        push_fix(16'd278, 16'd17999, 1'b1, 32'd1814);        // half turn, interpolated rate
        push_fix(16'd2000, 16'd18999, 1'b1, 32'd1829);       // turn at the base threshold
        push_fix(16'd2000, 16'd19000, 1'b1, 32'd1844);       // just over base, below the slope threshold
        push_fix(16'd2000, 16'hFFFF, 1'b1, 32'd1860);        // course out of range
        push_fix(16'd2000, 16'd0, 1'b1, 32'd1875);           // wrap back from out of range
        push_fix(16'd0, 16'd9000, 1'b1, 32'd1890);           // standing still
        push_fix(16'd100, 16'd9000, 1'b0, 32'd1891);         // course not valid
        push_fix(16'd2778, 16'd0, 1'b1, 32'h7FFF_FFFF);      // rate elapsed, latest time
        push_fix(16'd2778, 16'd18000, 1'b1, 32'h8000_0000);  // huge backward step
        push_fix(16'd2777, 16'd0, 1'b1, 32'h7FFF_FFFF);      // zero elapsed
        push_fix(16'd1000, 16'd0, 1'b1, 32'h7FFF_FFFF);      // stale, no beacon
        push_fix(16'h8000, 16'h8CA0, 1'b1, 32'h0000_0000);   // backward wrap to zero

        for (int round = 1; round <= ROUNDS; round++) begin
            wait_idle();
            program_settings(round);
            idle_pct = (round == 4) ? 0 : 34;
            repeat (FIXES_PER_ROUND) fixes_to_send.push_back(next_fix());
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && pending_decisions.size() == 0) begin
            $display("[adaptive_beacon_decider_core] OK");
        end else begin
            $display("[adaptive_beacon_decider_core] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/abd_pkg.sv
src/abd_mul.sv
src/abd_div.sv
src/adaptive_beacon_decider_core.sv
tb/adaptive_beacon_decider_core_test.sv
